@@ src/rstat_pkg.sv @@
// ---------------------------------------------------------------------------
// rstat_pkg: shared types and constants for the running statistics block
// Field widths, queue item layouts and the back-end sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package rstat_pkg;

   // fixed field widths
   localparam int CHANNEL_W   = 3;
   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = 48;
   localparam int CNT_OUT_W   = 32;

   // parameter defaults
   localparam int NUM_CHANNELS_DEF = 8;
   localparam int COUNT_BITS_DEF   = 32;
   localparam int FIFO_DEPTH       = 2;

   // mean clamp limits
   localparam logic [SUM_W-1:0] MEAN_POS_LIMIT = SUM_W'(32767);
   localparam logic [SUM_W-1:0] MEAN_NEG_LIMIT = SUM_W'(32768);
   localparam logic [SAMPLE_W-1:0] MEAN_POS_SAT = 16'h7fff;
   localparam logic [SAMPLE_W-1:0] MEAN_NEG_SAT = 16'h8000;

   // classified item between front and back
   typedef struct packed {
      logic                        in_range;
      logic [CHANNEL_W-1:0]        channel;
      logic signed [SAMPLE_W-1:0]  sample;
   } req_type;

   // result item
   typedef struct packed {
      logic [CHANNEL_W-1:0]        channel_out;
      logic signed [SAMPLE_W-1:0]  mean;
      logic [CNT_OUT_W-1:0]        sample_count;
      logic signed [SAMPLE_W-1:0]  minimum;
      logic signed [SAMPLE_W-1:0]  maximum;
      logic                        saturated;
   } rsp_type;

   // back-end sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_EMIT
   } back_state_type;

endpackage

`default_nettype wire

@@ src/per_channel_running_statistics.sv @@
// Per-channel running statistics. Each sample transfer names a channel and
// brings a signed 16-bit reading; the block adds it to that channel's
// 48-bit sum, bumps the count and returns one result with the updated mean
// (sum / count, truncated toward zero), count, and the smallest and largest
// positive reading seen. A channel whose count is full ignores the sample
// and flags saturated; a channel beyond the table returns zeros. Items are
// handled one at a time: queue pop, table RAM read, update, the mean divide
// (48 bit-serial quotient steps, then a done strobe) and the result hand-off.
// A two-entry queue on the input and one on the output let the source and
// the sink stall independently. Table entries are marked empty by reset at
// once, so no clearing pass is needed.
// ---------------------------------------------------------------------------
// per_channel_running_statistics: top level
// Input classification, update engine and result queue.
// ---------------------------------------------------------------------------
`default_nettype none

module per_channel_running_statistics #(
   parameter int NUM_CHANNELS = rstat_pkg::NUM_CHANNELS_DEF,
   parameter int COUNT_BITS   = rstat_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   output      logic                                  req_full,
   input  wire logic [rstat_pkg::CHANNEL_W-1:0]       req_channel,
   input  wire logic signed [rstat_pkg::SAMPLE_W-1:0] req_sample,
   output      logic                                  rsp_empty,
   input  wire logic                                  rsp_pop,
   output      logic [rstat_pkg::CHANNEL_W-1:0]       rsp_channel_out,
   output      logic signed [rstat_pkg::SAMPLE_W-1:0] rsp_mean,
   output      logic [rstat_pkg::CNT_OUT_W-1:0]       rsp_sample_count,
   output      logic signed [rstat_pkg::SAMPLE_W-1:0] rsp_minimum,
   output      logic signed [rstat_pkg::SAMPLE_W-1:0] rsp_maximum,
   output      logic                                  rsp_saturated
);

   localparam int RSP_W = $bits(rstat_pkg::rsp_type);

   rstat_pkg::req_type q_item;
   logic               q_empty, q_pop;
   rstat_pkg::rsp_type back_item, head_item;
   logic               out_push, out_full;
   logic [RSP_W-1:0]   out_rd_data;

   // accept and classify
   rstat_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_channel (req_channel),
      .req_sample  (req_sample),
      .q_pop       (q_pop),
      .q_empty     (q_empty),
      .q_item      (q_item)
   );

   // statistics update
   rstat_back #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_item (back_item)
   );

   // result queue
   rstat_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (rstat_pkg::FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (back_item),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (out_rd_data),
      .empty   (rsp_empty)
   );

   // result fields
   assign head_item        = out_rd_data;
   assign rsp_channel_out  = head_item.channel_out;
   assign rsp_mean         = head_item.mean;
   assign rsp_sample_count = head_item.sample_count;
   assign rsp_minimum      = head_item.minimum;
   assign rsp_maximum      = head_item.maximum;
   assign rsp_saturated    = head_item.saturated;

endmodule

`default_nettype wire

@@ src/rstat_ram.sv @@
// ---------------------------------------------------------------------------
// rstat_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rstat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int ADDR_W = 3
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/rstat_fifo.sv @@
// ---------------------------------------------------------------------------
// rstat_fifo: small synchronous queue
// Register-based queue with push/full and pop/empty sides; DEPTH is a
// power of two.
// ---------------------------------------------------------------------------
`default_nettype none

module rstat_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rstat_pkg::FIFO_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] rd_data,
   output      logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ src/rstat_front.sv @@
// ---------------------------------------------------------------------------
// rstat_front: input side of the statistics block
// Takes sample transfers, checks the channel against the table size and
// queues the classified item for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module rstat_front #(
   parameter int NUM_CHANNELS = rstat_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output      logic                                 req_full,
   input  wire logic [rstat_pkg::CHANNEL_W-1:0]      req_channel,
   input  wire logic signed [rstat_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                                 q_pop,
   output      logic                                 q_empty,
   output      rstat_pkg::req_type                   q_item
);

   localparam int REQ_W = $bits(rstat_pkg::req_type);

   rstat_pkg::req_type class_item;
   logic [REQ_W-1:0]   q_rd_data;

   // classify: channels beyond the table only echo back
   always_comb begin
      class_item.in_range = (32'(req_channel) < 32'(NUM_CHANNELS));
      class_item.channel  = req_channel;
      class_item.sample   = req_sample;
   end

   // queue toward the back end
   rstat_fifo #(
      .WIDTH (REQ_W),
      .DEPTH (rstat_pkg::FIFO_DEPTH)
   ) u_req_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (class_item),
      .full    (req_full),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   assign q_item = q_rd_data;

endmodule

`default_nettype wire

@@ src/rstat_div.sv @@
// ---------------------------------------------------------------------------
// rstat_div: bit-serial signed mean divider
// Restoring divide of a 48-bit signed sum by an unsigned count, one
// quotient bit per cycle, with the result clamped to 16 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module rstat_div #(
   parameter int CNT_W = rstat_pkg::COUNT_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [rstat_pkg::SUM_W-1:0]       dividend,
   input  wire logic [CNT_W-1:0]                  divisor,
   output      logic                              done,
   output      logic signed [rstat_pkg::SAMPLE_W-1:0] mean
);

   localparam int SUM_W  = rstat_pkg::SUM_W;
   localparam int STEP_W = $clog2(SUM_W);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              ge;
   logic [SUM_W-1:0]  neg_q;

   // one restoring step
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   // sequencing
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(SUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], ge};
         rem_in  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
   end

   // sign restore and clamp
   assign neg_q = ~quo_ff + SUM_W'(1);
   always_comb begin
      if (dvs_ff == '0) begin
         mean = '0;
      end else if (neg_ff) begin
         mean = (quo_ff > rstat_pkg::MEAN_NEG_LIMIT) ? rstat_pkg::MEAN_NEG_SAT
                                                    : neg_q[rstat_pkg::SAMPLE_W-1:0];
      end else begin
         mean = (quo_ff > rstat_pkg::MEAN_POS_LIMIT) ? rstat_pkg::MEAN_POS_SAT
                                                    : quo_ff[rstat_pkg::SAMPLE_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

@@ src/rstat_back.sv @@
// ---------------------------------------------------------------------------
// rstat_back: statistics update engine
// Reads an in-range channel's table RAM entry, folds in the sample, writes it
// back unless its count is full, runs the mean divide, then emits one result.
// ---------------------------------------------------------------------------
`default_nettype none

module rstat_back #(
   parameter int NUM_CHANNELS = rstat_pkg::NUM_CHANNELS_DEF,
   parameter int COUNT_BITS   = rstat_pkg::COUNT_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire rstat_pkg::req_type q_item,
   output      logic               q_pop,
   input  wire logic               out_full,
   output      logic               out_push,
   output      rstat_pkg::rsp_type out_item
);

   localparam int SUM_W    = rstat_pkg::SUM_W;
   localparam int SAMPLE_W = rstat_pkg::SAMPLE_W;
   localparam int ADDR_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int ENTRY_W  = SUM_W + COUNT_BITS + 2 * SAMPLE_W;

   rstat_pkg::back_state_type state_ff, state_in;
   rstat_pkg::req_type        item_ff, item_in;
   rstat_pkg::rsp_type        rsp_ff, rsp_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic [NUM_CHANNELS-1:0]   valid_ff, valid_in;

   logic [ADDR_W-1:0]          addr;
   logic                       ram_we, ram_re;
   logic [ENTRY_W-1:0]         ram_rd_data, ram_wr_data;
   logic [SUM_W-1:0]           cur_sum, new_sum, res_sum;
   logic [COUNT_BITS-1:0]      cur_count, new_count, res_count;
   logic signed [SAMPLE_W-1:0] cur_min, cur_max, new_min, new_max;
   logic [SUM_W-1:0]           count_wide;
   logic                       count_full, positive;
   logic                       div_start, div_done;
   logic signed [SAMPLE_W-1:0] div_mean;

   assign addr = ADDR_W'(item_ff.channel);

   // entry as read; never-written channels read as zero
   assign {cur_sum, cur_count, cur_min, cur_max} = rd_valid_ff ? ram_rd_data : '0;

   // fold the sample into the entry
   always_comb begin
      count_full = &cur_count;
      positive   = !item_ff.sample[SAMPLE_W-1] && (item_ff.sample != '0);
      new_sum    = cur_sum + {{(SUM_W - SAMPLE_W){item_ff.sample[SAMPLE_W-1]}},
                              item_ff.sample};
      new_count  = cur_count + COUNT_BITS'(1);
      new_min    = cur_min;
      new_max    = cur_max;
      if (positive) begin
         if (cur_min == '0) begin
            new_min = item_ff.sample;
            new_max = item_ff.sample;
         end else begin
            if (item_ff.sample > cur_max) begin
               new_max = item_ff.sample;
            end
            if (item_ff.sample < cur_min) begin
               new_min = item_ff.sample;
            end
         end
      end
      res_sum    = count_full ? cur_sum : new_sum;
      res_count  = count_full ? cur_count : new_count;
      count_wide = SUM_W'(res_count);
   end

   assign ram_wr_data = {new_sum, new_count, new_min, new_max};

   // sequencer: next state and outputs
   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      rsp_in      = rsp_ff;
      rd_valid_in = rd_valid_ff;
      valid_in    = valid_ff;
      q_pop       = 1'b0;
      ram_re      = 1'b0;
      ram_we      = 1'b0;
      div_start   = 1'b0;
      out_push    = 1'b0;
      case (state_ff)
         rstat_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               item_in = q_item;
               if (q_item.in_range) begin
                  state_in = rstat_pkg::ST_READ;
               end else begin
                  rsp_in             = '0;
                  rsp_in.channel_out = q_item.channel;
                  state_in           = rstat_pkg::ST_EMIT;
               end
            end
         end
         rstat_pkg::ST_READ: begin
            ram_re      = 1'b1;
            rd_valid_in = valid_ff[addr];
            state_in    = rstat_pkg::ST_UPDATE;
         end
         rstat_pkg::ST_UPDATE: begin
            ram_we = !count_full;
            if (!count_full) begin
               valid_in[addr] = 1'b1;
            end
            div_start           = 1'b1;
            rsp_in.channel_out  = item_ff.channel;
            rsp_in.sample_count = count_wide[rstat_pkg::CNT_OUT_W-1:0];
            rsp_in.minimum      = count_full ? cur_min : new_min;
            rsp_in.maximum      = count_full ? cur_max : new_max;
            rsp_in.saturated    = count_full;
            rsp_in.mean         = '0;
            state_in            = rstat_pkg::ST_DIVIDE;
         end
         rstat_pkg::ST_DIVIDE: begin
            if (div_done) begin
               rsp_in.mean = div_mean;
               state_in    = rstat_pkg::ST_EMIT;
            end
         end
         rstat_pkg::ST_EMIT: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = rstat_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rstat_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rstat_pkg::ST_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_ff      <= rsp_in;
      rd_valid_ff <= rd_valid_in;
   end

   assign out_item = rsp_ff;

   // channel table
   rstat_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (NUM_CHANNELS),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (addr),
      .rd_data (ram_rd_data)
   );

   // mean divider
   rstat_div #(
      .CNT_W (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (res_sum),
      .divisor  (res_count),
      .done     (div_done),
      .mean     (div_mean)
   );

   // table is written only for in-range items that are not saturated
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (item_ff.in_range && !count_full))
      else $error("table write for out-of-range or saturated item");

   // divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == rstat_pkg::ST_DIVIDE))
      else $error("divider done outside divide wait");

   // a popped item always leads either to a table read or straight to emit
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == rstat_pkg::ST_READ || state_ff == rstat_pkg::ST_EMIT))
      else $error("unexpected state after queue pop");

   // every update starts the divider and waits on it
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == rstat_pkg::ST_UPDATE) |=> (state_ff == rstat_pkg::ST_DIVIDE))
      else $error("update not followed by divide");

endmodule

`default_nettype wire
